>>> rtl/kcl_pkg.sv
// ----------------------------------------------------------------------------
// kcl_pkg
// Shared types and constants of the keypad code lock: key characters, mode and
// status codes, beat payload structs and the reset code.
// ----------------------------------------------------------------------------
package kcl_pkg;

   // Default code length (keys per entry)
   localparam int CODE_LEN_DEF = 4;

   // Item kinds
   localparam logic FUNC_KEY    = 1'b0;
   localparam logic FUNC_REMOTE = 1'b1;

   // Key characters
   localparam logic [7:0] KEY_NONE = 8'h00;
   localparam logic [7:0] KEY_STAR = 8'h2A;   // '*'
   localparam logic [7:0] KEY_HASH = 8'h23;   // '#'
   localparam logic [7:0] KEY_END  = 8'h41;   // 'A'
   localparam logic [7:0] KEY_ONE  = 8'h31;   // '1', first reset code character

   // Count saturation limit
   localparam logic [3:0] COUNT_MAX = 4'd15;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_UNLOCK  = 3'd1,
      MODE_OLD     = 3'd2,
      MODE_NEW     = 3'd3,
      MODE_CONFIRM = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      STATUS_NONE      = 3'd0,
      STATUS_UNLOCKED  = 3'd1,
      STATUS_WRONG     = 3'd2,
      STATUS_CHANGED   = 3'd3,
      STATUS_DIFFER    = 3'd4,
      STATUS_OLD_WRONG = 3'd5
   } status_type;

   typedef struct packed {
      logic        func;
      logic [7:0]  key_char;
      logic [31:0] remote_code;
      logic        remote_open;
   } req_type;

   typedef struct packed {
      status_type status;
      mode_type   mode_now;
      logic [3:0] keys_shown;
      logic       hold_open_level;
   } rsp_type;

   // Reset value of code character k: '1' + k
   function automatic logic [7:0] reset_char(input int k);
      reset_char = KEY_ONE + 8'(k);
   endfunction

endpackage

>>> rtl/kcl_in_stage.sv
// ----------------------------------------------------------------------------
// kcl_in_stage
// Input register: captures one request beat and holds it until the result
// register can take its outcome.
// ----------------------------------------------------------------------------
module kcl_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  kcl_pkg::req_type req_data,
   input  logic             advance,
   output logic             item_valid,
   output kcl_pkg::req_type item_data
);

   logic             valid_ff;
   logic             valid_in;
   kcl_pkg::req_type data_ff;

   // Hold while a captured beat cannot move on
   assign req_stall = valid_ff & ~advance;

   always_comb begin
      valid_in = valid_ff;
      if (!req_stall) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         data_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item_data  = data_ff;

endmodule

>>> rtl/kcl_core.sv
// ----------------------------------------------------------------------------
// kcl_core
// Lock state and its update: one key or remote command per fire, computing
// the next state and the result beat in a single pass.
// ----------------------------------------------------------------------------
module kcl_core #(
   parameter int CODE_LEN = kcl_pkg::CODE_LEN_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  kcl_pkg::req_type item,
   output kcl_pkg::rsp_type result
);

   localparam int         IDX_W    = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;
   localparam int         REMOTE_N = (CODE_LEN < 4) ? CODE_LEN : 4;
   localparam logic [3:0] LEN_C    = 4'(CODE_LEN);

   kcl_pkg::mode_type mode_ff, mode_in;
   logic [7:0]        stored_code_ff [CODE_LEN];
   logic [7:0]        stored_code_in [CODE_LEN];
   logic [7:0]        first_entry_ff [CODE_LEN];
   logic [7:0]        first_entry_in [CODE_LEN];
   logic [3:0]        match_count_ff, match_count_in;
   logic              entry_bad_ff, entry_bad_in;
   logic [3:0]        typed_count_ff, typed_count_in;
   logic [3:0]        first_count_ff, first_count_in;
   logic              hold_open_ff, hold_open_in;
   kcl_pkg::status_type status_in;

   logic [IDX_W-1:0]  idx;
   logic              in_range;
   logic              good;
   logic              ok;
   logic [7:0]        key;

   assign key      = item.key_char;
   assign idx      = typed_count_ff[IDX_W-1:0];
   assign in_range = (typed_count_ff < LEN_C);
   assign good     = !entry_bad_ff && (typed_count_ff == LEN_C) && (match_count_ff == LEN_C);

   always_comb begin
      mode_in        = mode_ff;
      stored_code_in = stored_code_ff;
      first_entry_in = first_entry_ff;
      match_count_in = match_count_ff;
      entry_bad_in   = entry_bad_ff;
      typed_count_in = typed_count_ff;
      first_count_in = first_count_ff;
      hold_open_in   = hold_open_ff;
      status_in      = kcl_pkg::STATUS_NONE;
      ok             = 1'b0;

      if (fire) begin
         if (item.func == kcl_pkg::FUNC_REMOTE) begin
            for (int k = 0; k < REMOTE_N; k++) begin
               stored_code_in[k] = item.remote_code[8*(3-k) +: 8];
            end
            hold_open_in = item.remote_open;
         end else if (key != kcl_pkg::KEY_NONE) begin
            case (mode_ff)
               kcl_pkg::MODE_UNLOCK, kcl_pkg::MODE_OLD,
               kcl_pkg::MODE_NEW, kcl_pkg::MODE_CONFIRM: begin
                  if (key == kcl_pkg::KEY_END) begin
                     // Entry ends: clear entry counters, pick next mode
                     match_count_in = 4'd0;
                     entry_bad_in   = 1'b0;
                     typed_count_in = 4'd0;
                     mode_in        = kcl_pkg::MODE_IDLE;
                     case (mode_ff)
                        kcl_pkg::MODE_UNLOCK: begin
                           status_in = good ? kcl_pkg::STATUS_UNLOCKED
                                            : kcl_pkg::STATUS_WRONG;
                        end
                        kcl_pkg::MODE_OLD: begin
                           if (good) begin
                              mode_in = kcl_pkg::MODE_NEW;
                           end else begin
                              status_in = kcl_pkg::STATUS_OLD_WRONG;
                           end
                        end
                        kcl_pkg::MODE_NEW: begin
                           first_count_in = typed_count_ff;
                           mode_in        = kcl_pkg::MODE_CONFIRM;
                        end
                        default: begin
                           if (good && first_count_ff == LEN_C) begin
                              stored_code_in = first_entry_ff;
                              status_in      = kcl_pkg::STATUS_CHANGED;
                           end else begin
                              status_in = kcl_pkg::STATUS_DIFFER;
                           end
                        end
                     endcase
                  end else begin
                     if (mode_ff == kcl_pkg::MODE_NEW) begin
                        if (in_range) begin
                           first_entry_in[idx] = key;
                        end
                     end else begin
                        if (mode_ff == kcl_pkg::MODE_CONFIRM) begin
                           ok = in_range && (typed_count_ff < first_count_ff)
                                && (first_entry_ff[idx] == key);
                        end else begin
                           ok = in_range && (stored_code_ff[idx] == key);
                        end
                        if (ok && !entry_bad_ff) begin
                           match_count_in = match_count_ff + 4'd1;
                        end else begin
                           entry_bad_in = 1'b1;
                        end
                     end
                     if (typed_count_ff < kcl_pkg::COUNT_MAX) begin
                        typed_count_in = typed_count_ff + 4'd1;
                     end
                  end
               end
               default: begin
                  // Idle: only '*' and '#' open an entry
                  if (key == kcl_pkg::KEY_STAR || key == kcl_pkg::KEY_HASH) begin
                     mode_in = (key == kcl_pkg::KEY_STAR) ? kcl_pkg::MODE_UNLOCK
                                                          : kcl_pkg::MODE_OLD;
                     match_count_in = 4'd0;
                     entry_bad_in   = 1'b0;
                     typed_count_in = 4'd0;
                  end else begin
                     mode_in = kcl_pkg::MODE_IDLE;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= kcl_pkg::MODE_IDLE;
         match_count_ff <= 4'd0;
         entry_bad_ff   <= 1'b0;
         typed_count_ff <= 4'd0;
         first_count_ff <= 4'd0;
         hold_open_ff   <= 1'b0;
         for (int k = 0; k < CODE_LEN; k++) begin
            stored_code_ff[k] <= kcl_pkg::reset_char(k);
         end
      end else begin
         mode_ff        <= mode_in;
         match_count_ff <= match_count_in;
         entry_bad_ff   <= entry_bad_in;
         typed_count_ff <= typed_count_in;
         first_count_ff <= first_count_in;
         hold_open_ff   <= hold_open_in;
         stored_code_ff <= stored_code_in;
      end
   end

   // New-entry buffer is only read at positions already typed
   always_ff @(posedge clock) begin
      first_entry_ff <= first_entry_in;
   end

   assign result.status          = status_in;
   assign result.mode_now        = mode_in;
   assign result.keys_shown      = typed_count_in;
   assign result.hold_open_level = hold_open_in;

endmodule

>>> rtl/kcl_out_stage.sv
// ----------------------------------------------------------------------------
// kcl_out_stage
// Result register: holds one response beat until the consumer takes it and
// tells the upstream stage when it may advance.
// ----------------------------------------------------------------------------
module kcl_out_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             item_valid,
   input  kcl_pkg::rsp_type result,
   output logic             advance,
   output logic             fire,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output kcl_pkg::rsp_type rsp_data
);

   logic             valid_ff;
   logic             valid_in;
   kcl_pkg::rsp_type data_ff;

   assign advance = ~valid_ff | ~rsp_stall;
   assign fire    = item_valid & advance;

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = item_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

>>> rtl/keypad_code_lock.sv
// Path: a request beat is held in the input register, then in the result
//   register, whose output is the response beat.
// Throughput: one beat per cycle while rsp_stall is low; the lock state and
//   result update in one short pass between the two registers.
// Reset: synchronous; mode idle, counters cleared, code "1234..." restored,
//   hold-open low, no beat in flight.
// ----------------------------------------------------------------------------
// keypad_code_lock
// Keypad combination lock controller: unlock entry, code change with confirm,
// and a remote command that sets the code and the hold-open level.
// ----------------------------------------------------------------------------
module keypad_code_lock #(
   parameter int CODE_LEN = kcl_pkg::CODE_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [7:0]  req_key_char,
   input  logic [31:0] req_remote_code,
   input  logic        req_remote_open,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [2:0]  rsp_mode_now,
   output logic [3:0]  rsp_keys_shown,
   output logic        rsp_hold_open_level
);

   kcl_pkg::req_type req_data;
   kcl_pkg::req_type item_data;
   kcl_pkg::rsp_type result;
   kcl_pkg::rsp_type rsp_data;
   logic             item_valid;
   logic             advance;
   logic             fire;

   // Bundle the request fields into one beat
   assign req_data.func        = req_func;
   assign req_data.key_char    = req_key_char;
   assign req_data.remote_code = req_remote_code;
   assign req_data.remote_open = req_remote_open;

   // Input register: holds the beat while the result register is blocked
   kcl_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .advance    (advance),
      .item_valid (item_valid),
      .item_data  (item_data)
   );

   // Lock state: updates only when the beat moves into the result register,
   // so each beat is applied exactly once regardless of stalls
   kcl_core #(
      .CODE_LEN (CODE_LEN)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item_data),
      .result (result)
   );

   // Result register: advance whenever empty or being drained this cycle
   kcl_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .result     (result),
      .advance    (advance),
      .fire       (fire),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   // Unpack the response beat
   assign rsp_status          = rsp_data.status;
   assign rsp_mode_now        = rsp_data.mode_now;
   assign rsp_keys_shown      = rsp_data.keys_shown;
   assign rsp_hold_open_level = rsp_data.hold_open_level;

endmodule
